FILE: design/assert_macros.svh
// Assertion helpers for the RTL files (included by sorted_priority_queue).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int SPQ_DEPTH   = 16;
    localparam int COORD_W     = 64;
    localparam int PRIO_W      = 8;
    localparam int OCC_W       = 5;
    localparam int S_TDATA_W   = 200;
    localparam int M_TDATA_W   = 208;

    // command carried in s_tuser
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } spq_cmd_t;

    // status carried in m_tuser
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spq_status_t;

    // one held entry
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } spq_entry_t;

    localparam spq_entry_t ENTRY_ZERO = '0;

    // operation broadcast to every cell
    typedef struct packed {
        logic       push;
        logic       pop;
        spq_entry_t ins;
    } spq_op_t;

endpackage

`default_nettype wire

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// pushed priority and shifts toward either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       aclk,
    input  wire spq_op_t    op_i,
    input  wire logic       occupied_i,   // slot index below entry count
    input  wire spq_entry_t prev_entry_i, // neighbor toward the front
    input  wire logic       prev_after_i, // new entry goes behind neighbor
    input  wire spq_entry_t next_entry_i, // neighbor toward the back
    output spq_entry_t      entry_o,
    output logic            after_o       // new entry goes behind this slot
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // equal priorities keep arrival order: new entry goes behind them
    assign after_o = occupied_i && (entry_reg.prio <= op_i.ins.prio);
    assign entry_o = entry_reg;

    // keep, take the new entry, or shift by one slot
    always_comb begin
        entry_next = entry_reg;
        if (op_i.push) begin
            if (!after_o) begin
                entry_next = prev_after_i ? op_i.ins : prev_entry_i;
            end
        end else if (op_i.pop) begin
            entry_next = next_entry_i;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser selects push or pop.
//   A push stores the coordinate words with their priority; a smaller
//   priority leaves first and equal priorities leave in arrival order.
//   A pop returns the front entry. Every input word yields one result
//   word on m_tvalid/m_tready with status, popped entry (zero unless a
//   pop succeeds), occupancy and an empty flag.
//   The result is registered. While m_tready is high, one word per
//   cycle is sustained: every slot compares and shifts in the same cycle.
//   A push to a full queue is refused (status full), a pop from an empty
//   queue returns status empty; neither changes the contents.
//   Reset empties the queue and drops m_tvalid at the next clock edge.
//   While the receiver stalls, the result holds and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pos_x [63:0], pos_y [127:64], pos_z [191:128], priority_req [199:192]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd [0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_x [63:0], out_y [127:64], out_z [191:128], out_priority [199:192],
    // occupancy [204:200], is_empty [205], zero [207:206]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // status [1:0]
    output logic [1:0]                m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    logic            accept;
    logic            is_pop;
    logic            full;
    logic            empty;
    spq_op_t         op;
    spq_entry_t      entries [DEPTH];
    logic            after   [DEPTH];

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW+4:0]   count_ext;

    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [1:0]           m_tuser_reg;
    logic [1:0]           m_tuser_next;

    // handshake: output register frees up when taken
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (s_tuser == CMD_POP);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    // operation broadcast to the chain
    always_comb begin
        op.push     = accept && !is_pop && !full;
        op.pop      = accept && is_pop && !empty;
        op.ins.x    = s_tdata[63:0];
        op.ins.y    = s_tdata[127:64];
        op.ins.z    = s_tdata[191:128];
        op.ins.prio = s_tdata[199:192];
    end

    // chain of slot cells, front at index 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_entry_t prev_entry;
        logic       prev_after;
        spq_entry_t next_entry;

        // nothing ahead of the front slot: it takes the new entry itself
        if (i == 0) begin : g_front
            assign prev_entry = ENTRY_ZERO;
            assign prev_after = 1'b1;
        end else begin : g_mid
            assign prev_entry = entries[i-1];
            assign prev_after = after[i-1];
        end

        if (i == DEPTH - 1) begin : g_back
            assign next_entry = ENTRY_ZERO;
        end else begin : g_rest
            assign next_entry = entries[i+1];
        end

        spq_cell u_cell (
            .aclk         (aclk),
            .op_i         (op),
            .occupied_i   (CW'(i) < count_reg),
            .prev_entry_i (prev_entry),
            .prev_after_i (prev_after),
            .next_entry_i (next_entry),
            .entry_o      (entries[i]),
            .after_o      (after[i])
        );
    end

    // entry count
    always_comb begin
        count_next = count_reg;
        if (op.push) begin
            count_next = count_reg + CW'(1);
        end else if (op.pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_ext = {5'b0, count_next};

    // result word
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tuser_next  = STATUS_OK;
            if (is_pop && empty) begin
                m_tuser_next = STATUS_EMPTY;
            end else if (!is_pop && full) begin
                m_tuser_next = STATUS_FULL;
            end
            if (op.pop) begin
                m_tdata_next[63:0]    = entries[0].x;
                m_tdata_next[127:64]  = entries[0].y;
                m_tdata_next[191:128] = entries[0].z;
                m_tdata_next[199:192] = entries[0].prio;
            end
            m_tdata_next[204:200] = count_ext[OCC_W-1:0];
            m_tdata_next[205]     = (count_next == '0);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `SPQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `SPQ_ASSERT_IMP(a_front_sorted, aclk, aresetn, count_reg >= CW'(2),
                    entries[0].prio <= entries[1].prio)
    `SPQ_ASSERT_NXT(a_full_refused, aclk, aresetn, accept && !is_pop && full,
                    m_tuser == STATUS_FULL && $stable(count_reg))
    `SPQ_ASSERT_NXT(a_pop_count, aclk, aresetn, accept && is_pop && !empty,
                    count_reg == $past(count_reg) - CW'(1))

endmodule

`default_nettype wire
